// ===== rtl/fcdbw_pkg.sv =====
package fcdbw_pkg;

  // Framebuffer geometry
  localparam int FB_WIDTH  = 256;
  localparam int FB_HEIGHT = 256;
  localparam int PIX_COUNT = FB_WIDTH * FB_HEIGHT;
  localparam int PIX_W     = $clog2(PIX_COUNT);
  localparam int XW        = $clog2(FB_WIDTH);
  localparam int YW        = $clog2(FB_HEIGHT);

  // Signed width for coordinate compares (coordinate, viewport end, fb bound)
  localparam int CMP_W     = 13;

  // Q2.14 depth, 1.0 = 16384
  localparam int DEPTH_ONE = 16384;

  // Queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // Configuration port address width (six 32-bit registers)
  localparam int CFG_AW    = 5;

  typedef logic signed [11:0] coord_t;
  typedef logic signed [15:0] depth_t;
  typedef logic        [7:0]  chan_t;
  typedef logic        [7:0]  vp_pos_t;
  typedef logic        [8:0]  vp_size_t;
  typedef logic [PIX_W-1:0]   pix_idx_t;

  localparam depth_t Z_MIN = depth_t'(-DEPTH_ONE);
  localparam depth_t Z_MAX = depth_t'(DEPTH_ONE);

  typedef enum logic [1:0] {
    OUTC_WRITTEN    = 2'd0,
    OUTC_CLIPPED    = 2'd1,
    OUTC_DEPTH_FAIL = 2'd2
  } outcome_t;

  // Register indexes, in address order
  typedef enum logic [2:0] {
    REG_VP_X     = 3'd0,
    REG_VP_Y     = 3'd1,
    REG_VP_W     = 3'd2,
    REG_VP_H     = 3'd3,
    REG_DEPTH_EN = 3'd4,
    REG_BLEND_EN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    vp_pos_t  vp_x;
    vp_pos_t  vp_y;
    vp_size_t vp_w;
    vp_size_t vp_h;
    logic     depth_test_en;
    logic     blend_en;
  } cfg_t;

  // Classified fragment as it travels through the queue
  typedef struct packed {
    logic     clip;
    pix_idx_t idx;
    depth_t   z;
    chan_t    r;
    chan_t    g;
    chan_t    b;
    chan_t    a;
  } q_item_t;

  // One pixel of the framebuffer; alpha is not stored
  typedef struct packed {
    depth_t z;
    chan_t  b;
    chan_t  g;
    chan_t  r;
  } pix_word_t;

endpackage

// ===== rtl/fcdbw_ifs.sv =====
// Fragment channel
interface fcdbw_frag_if import fcdbw_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t frag_x;
  coord_t frag_y;
  depth_t frag_depth;
  chan_t  frag_red;
  chan_t  frag_green;
  chan_t  frag_blue;
  chan_t  frag_alpha;

  modport source (
    output valid, frag_x, frag_y, frag_depth,
    output frag_red, frag_green, frag_blue, frag_alpha,
    input  ready
  );
  modport sink (
    input  valid, frag_x, frag_y, frag_depth,
    input  frag_red, frag_green, frag_blue, frag_alpha,
    output ready
  );
endinterface

// Result channel
interface fcdbw_res_if import fcdbw_pkg::*; ();
  logic     valid;
  logic     ready;
  outcome_t outcome;
  chan_t    out_red;
  chan_t    out_green;
  chan_t    out_blue;
  chan_t    out_alpha;
  depth_t   out_depth;

  modport source (
    output valid, outcome, out_red, out_green, out_blue, out_alpha, out_depth,
    input  ready
  );
  modport sink (
    input  valid, outcome, out_red, out_green, out_blue, out_alpha, out_depth,
    output ready
  );
endinterface

// ===== rtl/fcdbw_regs.sv =====
module fcdbw_regs import fcdbw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // Register file, written in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vp_x          <= '0;
      cfg_r.vp_y          <= '0;
      cfg_r.vp_w          <= vp_size_t'(256);
      cfg_r.vp_h          <= vp_size_t'(256);
      cfg_r.depth_test_en <= 1'b0;
      cfg_r.blend_en      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_VP_X:     cfg_r.vp_x          <= pwdata[7:0];
        REG_VP_Y:     cfg_r.vp_y          <= pwdata[7:0];
        REG_VP_W:     cfg_r.vp_w          <= pwdata[8:0];
        REG_VP_H:     cfg_r.vp_h          <= pwdata[8:0];
        REG_DEPTH_EN: cfg_r.depth_test_en <= pwdata[0];
        REG_BLEND_EN: cfg_r.blend_en      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_VP_X:     prdata = 32'(cfg_r.vp_x);
      REG_VP_Y:     prdata = 32'(cfg_r.vp_y);
      REG_VP_W:     prdata = 32'(cfg_r.vp_w);
      REG_VP_H:     prdata = 32'(cfg_r.vp_h);
      REG_DEPTH_EN: prdata = 32'(cfg_r.depth_test_en);
      REG_BLEND_EN: prdata = 32'(cfg_r.blend_en);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/fcdbw_front.sv =====
module fcdbw_front import fcdbw_pkg::*; (
  fcdbw_frag_if.sink in_frag,
  input  cfg_t       cfg,
  input  logic       q_full,
  input  logic       busy,
  output logic       push,
  output q_item_t    push_item
);

  localparam logic signed [CMP_W-1:0] FB_W_S = CMP_W'(FB_WIDTH);
  localparam logic signed [CMP_W-1:0] FB_H_S = CMP_W'(FB_HEIGHT);

  logic signed [CMP_W-1:0] x_s, y_s;
  logic signed [CMP_W-1:0] vx_s, vy_s, vx_end_s, vy_end_s;
  logic                    out_vp, out_fb, out_z;

  assign in_frag.ready = !q_full && !busy;
  assign push          = in_frag.valid && in_frag.ready;

  // Coordinates and viewport edges in a common signed width
  assign x_s      = CMP_W'(in_frag.frag_x);
  assign y_s      = CMP_W'(in_frag.frag_y);
  assign vx_s     = CMP_W'(cfg.vp_x);
  assign vy_s     = CMP_W'(cfg.vp_y);
  assign vx_end_s = CMP_W'(cfg.vp_x) + CMP_W'(cfg.vp_w);
  assign vy_end_s = CMP_W'(cfg.vp_y) + CMP_W'(cfg.vp_h);

  // Clip classification
  assign out_vp = (x_s < vx_s) || (x_s >= vx_end_s) || (y_s < vy_s) || (y_s >= vy_end_s);
  assign out_fb = (x_s < 0) || (x_s >= FB_W_S) || (y_s < 0) || (y_s >= FB_H_S);
  assign out_z  = (in_frag.frag_depth < Z_MIN) || (in_frag.frag_depth > Z_MAX);

  // Queue entry; the pixel index only matters for unclipped fragments
  always_comb begin
    push_item.clip = out_vp || out_fb || out_z;
    push_item.idx  = pix_idx_t'(pix_idx_t'(y_s[YW-1:0]) * pix_idx_t'(FB_WIDTH)
                     + pix_idx_t'(x_s[XW-1:0]));
    push_item.z    = in_frag.frag_depth;
    push_item.r    = in_frag.frag_red;
    push_item.g    = in_frag.frag_green;
    push_item.b    = in_frag.frag_blue;
    push_item.a    = in_frag.frag_alpha;
  end

endmodule

// ===== rtl/fcdbw_queue.sv =====
module fcdbw_queue import fcdbw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_vld,
  output q_item_t head_item
);

  q_item_t           ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_vld  = (cnt_r != '0);
  assign head_item = ent_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/fcdbw_back.sv =====
module fcdbw_back import fcdbw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    head_vld,
  input  q_item_t head_item,
  output logic    pop,
  output logic    busy,
  fcdbw_res_if.source out_res
);

  localparam pix_word_t CLR_WORD = '{z: Z_MAX, b: '0, g: '0, r: '0};

  // (s*a + d*(255-a)) / 255, floor; the divide is (v + (v>>8) + 1) >> 8
  function automatic chan_t mix8(chan_t s, chan_t d, chan_t a);
    logic [15:0] p;
    logic [16:0] q;
    p = {8'd0, s} * {8'd0, a} + {8'd0, d} * {8'd0, 8'd255 - a};
    q = {1'b0, p} + 17'(p[15:8]) + 17'd1;
    return q[15:8];
  endfunction

  pix_word_t mem [PIX_COUNT];

  logic      clr_act_r;
  pix_idx_t  clr_cnt_r;

  logic      s1_vld_r;
  q_item_t   s1_item_r;
  logic      fwd_hit_r;
  pix_word_t fwd_word_r;
  pix_word_t rd_word_r;

  logic      out_vld_r;
  outcome_t  res_outc_r;
  chan_t     res_red_r, res_green_r, res_blue_r, res_alpha_r;
  depth_t    res_depth_r;

  logic      out_free, s1_adv, depth_fail, wr_pix, we;
  pix_word_t dst, wd;
  pix_idx_t  wa;
  chan_t     r_nxt, g_nxt, b_nxt;
  outcome_t  outc_nxt;

  assign busy     = clr_act_r;
  assign out_free = !out_vld_r || out_res.ready;
  assign s1_adv   = s1_vld_r && out_free;
  assign pop      = head_vld && (!s1_vld_r || s1_adv) && !clr_act_r;

  // Stored pixel, bypassing the write that landed with the read
  assign dst        = fwd_hit_r ? fwd_word_r : rd_word_r;
  assign depth_fail = cfg.depth_test_en && (dst.z < s1_item_r.z);

  // Blend and classify
  always_comb begin
    if (cfg.blend_en) begin
      r_nxt = mix8(s1_item_r.r, dst.r, s1_item_r.a);
      g_nxt = mix8(s1_item_r.g, dst.g, s1_item_r.a);
      b_nxt = mix8(s1_item_r.b, dst.b, s1_item_r.a);
    end else begin
      r_nxt = s1_item_r.r;
      g_nxt = s1_item_r.g;
      b_nxt = s1_item_r.b;
    end
    priority if (s1_item_r.clip) begin
      outc_nxt = OUTC_CLIPPED;
    end else if (depth_fail) begin
      outc_nxt = OUTC_DEPTH_FAIL;
    end else begin
      outc_nxt = OUTC_WRITTEN;
    end
  end

  assign wr_pix = s1_adv && (outc_nxt == OUTC_WRITTEN);

  // Single write port: clearing sweep or pixel commit
  always_comb begin
    we = clr_act_r || wr_pix;
    if (clr_act_r) begin
      wa = clr_cnt_r;
      wd = CLR_WORD;
    end else begin
      wa = s1_item_r.idx;
      wd = '{z: s1_item_r.z, b: b_nxt, g: g_nxt, r: r_nxt};
    end
  end

  // Framebuffer memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (pop) begin
      rd_word_r <= mem[head_item.idx];
    end
  end

  // Control: clearing sweep, stage and output valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (clr_act_r) begin
        if (clr_cnt_r == pix_idx_t'(PIX_COUNT-1)) begin
          clr_act_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (pop) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_res.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Stage payload and bypass capture
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r  <= head_item;
      fwd_hit_r  <= we && (wa == head_item.idx);
      fwd_word_r <= wd;
    end
  end

  // Output register; discarded transactions carry zeros
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_outc_r <= outc_nxt;
      if (outc_nxt == OUTC_WRITTEN) begin
        res_red_r   <= r_nxt;
        res_green_r <= g_nxt;
        res_blue_r  <= b_nxt;
        res_alpha_r <= s1_item_r.a;
        res_depth_r <= s1_item_r.z;
      end else begin
        res_red_r   <= '0;
        res_green_r <= '0;
        res_blue_r  <= '0;
        res_alpha_r <= '0;
        res_depth_r <= '0;
      end
    end
  end

  assign out_res.valid     = out_vld_r;
  assign out_res.outcome   = res_outc_r;
  assign out_res.out_red   = res_red_r;
  assign out_res.out_green = res_green_r;
  assign out_res.out_blue  = res_blue_r;
  assign out_res.out_alpha = res_alpha_r;
  assign out_res.out_depth = res_depth_r;

endmodule

// ===== rtl/fragment_clip_depth_blend_write.sv =====
// Channel   Role     Transaction
// in_frag   sink     one fragment: coordinates, Q2.14 depth, RGBA
// out_res   source   one result per fragment: outcome, colour, depth
// APB       slave    register write/read, pready tied high
//
// One fragment a cycle sustained while out_res is not stalled; each fragment passes
// through the queue, the pixel read and the output register on the way to its result.
// Pixel read-modify-write on one single-port-write memory, with a bypass of
// the write committed in the same cycle as the read.
// After reset a clearing sweep over all FB_WIDTH*FB_HEIGHT pixels (65536) runs with
// in_frag.ready low; register writes are taken throughout.
// A stalled output holds the back end; the four-entry queue absorbs input
// until it fills, then in_frag.ready drops.
module fragment_clip_depth_blend_write import fcdbw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fcdbw_frag_if.sink        in_frag,
  fcdbw_res_if.source       out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    q_full, push, pop, head_vld, busy;
  q_item_t push_item, head_item;

  // Configuration registers
  fcdbw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Accept and clip
  fcdbw_front u_front (
    .in_frag   (in_frag),
    .cfg       (cfg),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  fcdbw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_vld  (head_vld),
    .head_item (head_item)
  );

  // Depth test, blend, framebuffer write
  fcdbw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_vld  (head_vld),
    .head_item (head_item),
    .pop       (pop),
    .busy      (busy),
    .out_res   (out_res)
  );

  // Discarded fragments report all-zero colour and depth
  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.outcome != OUTC_WRITTEN) |->
      (out_res.out_red == '0) && (out_res.out_green == '0) && (out_res.out_blue == '0) &&
      (out_res.out_alpha == '0) && (out_res.out_depth == '0))
    else $error("discarded transaction carries non-zero payload");

  // A written depth always lies within the near and far planes
  a_written_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.outcome == OUTC_WRITTEN) |->
      (out_res.out_depth >= Z_MIN) && (out_res.out_depth <= Z_MAX))
    else $error("written depth outside clip range");

  // No fragment is taken while the clearing sweep starts
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_frag.ready)
    else $error("fragment accepted during framebuffer clear");

endmodule

// ===== tb/tb_fragment_clip_depth_blend_write.sv =====
`timescale 1ns / 1ps

module tb_fragment_clip_depth_blend_write;
  import fcdbw_pkg::*;

  // Number of registers in the map
  localparam int REG_COUNT  = 6;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4 * PIX_COUNT;

  typedef struct packed {
    coord_t x;
    coord_t y;
    depth_t z;
    chan_t  r;
    chan_t  g;
    chan_t  b;
    chan_t  a;
  } frag_t;

  typedef struct packed {
    outcome_t outcome;
    chan_t    r;
    chan_t    g;
    chan_t    b;
    chan_t    a;
    depth_t   z;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  fcdbw_frag_if frag_ch ();
  fcdbw_res_if  res_ch ();

  fragment_clip_depth_blend_write uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_frag (frag_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Shadow of the register file
  int vp_left, vp_bottom, vp_width, vp_height;
  bit ztest_on, blend_on;

  // Shadow framebuffer
  logic [31:0] colour_mem [PIX_COUNT];
  depth_t      zbuf_mem   [PIX_COUNT];

  frag_t         pending_frags [$];
  pixel_result_t predicted_pixels [$];

  int frags_queued, frags_taken, mismatches, reg_errors, settings_used;
  int n_written, n_clipped, n_zfail;
  int gap_left, stall_left, hold_left, hold_requests, holds_done;
  int quiet_cycles;
  bit no_idle;

  frag_t         next_frag, taken_frag;
  pixel_result_t want;

  // Clip, depth test, blend and write one fragment against the shadow state
  function automatic pixel_result_t shade_fragment(frag_t f);
    pixel_result_t res;
    int x, y, z, idx, r, g, b, al;
    logic [31:0] old;
    x = int'(f.x);
    y = int'(f.y);
    z = int'(f.z);
    r = int'(f.r);
    g = int'(f.g);
    b = int'(f.b);
    al = int'(f.a);
    res.outcome = OUTC_CLIPPED;
    res.r = '0;
    res.g = '0;
    res.b = '0;
    res.a = '0;
    res.z = '0;
    if (x < vp_left || x >= vp_left + vp_width || y < vp_bottom ||
        y >= vp_bottom + vp_height || x < 0 || x >= FB_WIDTH || y < 0 ||
        y >= FB_HEIGHT || z < -DEPTH_ONE || z > DEPTH_ONE) begin
      n_clipped++;
      return res;
    end
    idx = y * FB_WIDTH + x;
    if (ztest_on && int'(zbuf_mem[idx]) < z) begin
      res.outcome = OUTC_DEPTH_FAIL;
      n_zfail++;
      return res;
    end
    if (blend_on) begin
      old = colour_mem[idx];
      r = (r * al + int'(old[7:0]) * (255 - al)) / 255;
      g = (g * al + int'(old[15:8]) * (255 - al)) / 255;
      b = (b * al + int'(old[23:16]) * (255 - al)) / 255;
    end
    colour_mem[idx] = {f.a, chan_t'(b), chan_t'(g), chan_t'(r)};
    zbuf_mem[idx] = f.z;
    res.outcome = OUTC_WRITTEN;
    res.r = chan_t'(r);
    res.g = chan_t'(g);
    res.b = chan_t'(b);
    res.a = f.a;
    res.z = f.z;
    n_written++;
    return res;
  endfunction

  // Random fragment aimed mostly at the drawable area of the current settings
  function automatic frag_t random_fragment();
    frag_t f;
    int lo_x, hi_x, lo_y, hi_y, pick;
    f.x = coord_t'($urandom);
    f.y = coord_t'($urandom);
    f.z = depth_t'($urandom);
    f.r = chan_t'($urandom);
    f.g = chan_t'($urandom);
    f.b = chan_t'($urandom);
    f.a = chan_t'($urandom);
    if ($urandom_range(0, 4) == 0) f.a = $urandom_range(0, 1) ? 8'hff : 8'h00;
    lo_x = vp_left;
    lo_y = vp_bottom;
    hi_x = ((vp_left + vp_width < FB_WIDTH) ? vp_left + vp_width : FB_WIDTH) - 1;
    hi_y = ((vp_bottom + vp_height < FB_HEIGHT) ? vp_bottom + vp_height : FB_HEIGHT) - 1;
    pick = $urandom_range(0, 99);
    // noise, or nothing drawable at all
    if (pick >= 85 || hi_x < lo_x || hi_y < lo_y) return f;
    if (pick < 45) begin
      // small hot spot: back-to-back hits on the same pixels
      f.x = coord_t'(lo_x + int'($urandom_range(0, (hi_x - lo_x < 3) ? hi_x - lo_x : 3)));
      f.y = coord_t'(lo_y + int'($urandom_range(0, (hi_y - lo_y < 3) ? hi_y - lo_y : 3)));
    end else if (pick < 75) begin
      f.x = coord_t'(int'($urandom_range(lo_x, hi_x)));
      f.y = coord_t'(int'($urandom_range(lo_y, hi_y)));
    end else begin
      // one pixel past an edge
      f.x = coord_t'(int'($urandom_range(lo_x, hi_x)));
      f.y = coord_t'(int'($urandom_range(lo_y, hi_y)));
      if ($urandom_range(0, 1)) f.x = coord_t'($urandom_range(0, 1) ? lo_x - 1 : hi_x + 1);
      else f.y = coord_t'($urandom_range(0, 1) ? lo_y - 1 : hi_y + 1);
    end
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      f.z = depth_t'(int'($urandom_range(0, 2 * DEPTH_ONE)) - DEPTH_ONE);
    end else if (pick < 18) begin
      case ($urandom_range(0, 3))
        0: f.z = depth_t'(-DEPTH_ONE - 1);
        1: f.z = depth_t'(-DEPTH_ONE);
        2: f.z = depth_t'(DEPTH_ONE);
        default: f.z = depth_t'(DEPTH_ONE + 1);
      endcase
    end
    return f;
  endfunction

  function automatic void push_frag(frag_t f);
    pending_frags.push_back(f);
    frags_queued++;
  endfunction

  task automatic queue_frag(input int x, input int y, input int z, input int r,
                            input int g, input int b, input int a);
    frag_t f;
    f.x = coord_t'(x);
    f.y = coord_t'(y);
    f.z = depth_t'(z);
    f.r = chan_t'(r);
    f.g = chan_t'(g);
    f.b = chan_t'(b);
    f.a = chan_t'(a);
    push_frag(f);
  endtask

  // One APB transfer: setup then access
  task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] unused;
    apb_access(1'b1, idx, data, unused);
    case (idx)
      REG_VP_X:     vp_left   = int'(data[7:0]);
      REG_VP_Y:     vp_bottom = int'(data[7:0]);
      REG_VP_W:     vp_width  = int'(data[8:0]);
      REG_VP_H:     vp_height = int'(data[8:0]);
      REG_DEPTH_EN: ztest_on  = data[0];
      REG_BLEND_EN: blend_on  = data[0];
      default: ;
    endcase
  endtask

  // Read back every register and compare with the shadow copy
  task automatic check_registers();
    logic [31:0] got, ref_val;
    logic [2:0]  ri;
    for (int i = 0; i < REG_COUNT; i++) begin
      ri = 3'(i);
      apb_access(1'b0, ri, $urandom, got);
      case (ri)
        REG_VP_X:     ref_val = vp_left;
        REG_VP_Y:     ref_val = vp_bottom;
        REG_VP_W:     ref_val = vp_width;
        REG_VP_H:     ref_val = vp_height;
        REG_DEPTH_EN: ref_val = 32'(ztest_on);
        default:      ref_val = 32'(blend_on);
      endcase
      if (got !== ref_val) begin
        $error("register %0d: expected 0x%0h, actual 0x%0h", ri, ref_val, got);
        reg_errors++;
      end
    end
  endtask

  // Program all registers; junk in the upper bits checks the width masking
  task automatic apply_settings(input int vx, input int vy, input int vw, input int vh,
                                input bit zt, input bit bl);
    cfg_write(REG_VP_X, ($urandom << 8) | vx);
    cfg_write(REG_VP_Y, ($urandom << 8) | vy);
    cfg_write(REG_VP_W, ($urandom << 9) | vw);
    cfg_write(REG_VP_H, ($urandom << 9) | vh);
    cfg_write(REG_DEPTH_EN, ($urandom << 1) | zt);
    cfg_write(REG_BLEND_EN, ($urandom << 1) | bl);
    // addresses past the register list must be ignored
    cfg_write(3'(REG_COUNT + $urandom_range(0, 1)), $urandom);
    check_registers();
    settings_used++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (frags_taken != frags_queued || predicted_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Fragment driver
  always @(posedge clk) begin
    if (!rst_n) begin
      frag_ch.valid      <= 1'b0;
      frag_ch.frag_x     <= '0;
      frag_ch.frag_y     <= '0;
      frag_ch.frag_depth <= '0;
      frag_ch.frag_red   <= '0;
      frag_ch.frag_green <= '0;
      frag_ch.frag_blue  <= '0;
      frag_ch.frag_alpha <= '0;
    end else begin
      if (frag_ch.valid && frag_ch.ready) begin
        taken_frag.x = frag_ch.frag_x;
        taken_frag.y = frag_ch.frag_y;
        taken_frag.z = frag_ch.frag_depth;
        taken_frag.r = frag_ch.frag_red;
        taken_frag.g = frag_ch.frag_green;
        taken_frag.b = frag_ch.frag_blue;
        taken_frag.a = frag_ch.frag_alpha;
        predicted_pixels.push_back(shade_fragment(taken_frag));
        frags_taken++;
      end
      if (!frag_ch.valid || frag_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          frag_ch.valid <= 1'b0;
        end else if (pending_frags.size() > 0) begin
          next_frag = pending_frags.pop_front();
          frag_ch.valid      <= 1'b1;
          frag_ch.frag_x     <= next_frag.x;
          frag_ch.frag_y     <= next_frag.y;
          frag_ch.frag_depth <= next_frag.z;
          frag_ch.frag_red   <= next_frag.r;
          frag_ch.frag_green <= next_frag.g;
          frag_ch.frag_blue  <= next_frag.b;
          frag_ch.frag_alpha <= next_frag.a;
          if (!no_idle && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          frag_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generation
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_pixels.size() == 0) begin
          $error("result transaction with no fragment outstanding");
          mismatches++;
        end else begin
          want = predicted_pixels.pop_front();
          if (res_ch.outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, res_ch.outcome);
            mismatches++;
          end
          if (res_ch.out_red !== want.r) begin
            $error("out_red: expected %0d, actual %0d", want.r, res_ch.out_red);
            mismatches++;
          end
          if (res_ch.out_green !== want.g) begin
            $error("out_green: expected %0d, actual %0d", want.g, res_ch.out_green);
            mismatches++;
          end
          if (res_ch.out_blue !== want.b) begin
            $error("out_blue: expected %0d, actual %0d", want.b, res_ch.out_blue);
            mismatches++;
          end
          if (res_ch.out_alpha !== want.a) begin
            $error("out_alpha: expected %0d, actual %0d", want.a, res_ch.out_alpha);
            mismatches++;
          end
          if (res_ch.out_depth !== want.z) begin
            $error("out_depth: expected %0d, actual %0d", want.z, res_ch.out_depth);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (holds_done < hold_requests) begin
        // long back-pressure so the block fills and drops its input ready
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((frag_ch.valid && frag_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and phase sequencing
  initial begin
    int vx, vy, vw, vh, n;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    vp_left   = 0;
    vp_bottom = 0;
    vp_width  = 256;
    vp_height = 256;
    ztest_on  = 1'b0;
    blend_on  = 1'b0;
    for (int i = 0; i < PIX_COUNT; i++) begin
      colour_mem[i] = '0;
      zbuf_mem[i]   = depth_t'(DEPTH_ONE);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, then directed fragments with depth test and blending on
    check_registers();
    apply_settings(0, 0, 256, 256, 1'b1, 1'b1);
    queue_frag(0, 0, 0, 255, 255, 255, 255);
    queue_frag(255, 255, DEPTH_ONE, 10, 20, 30, 0);          // equal to far plane
    queue_frag(255, 255, DEPTH_ONE, 200, 100, 50, 128);
    queue_frag(0, 0, -DEPTH_ONE, 0, 0, 0, 128);
    queue_frag(0, 0, 100, 9, 9, 9, 9);                       // behind stored depth
    queue_frag(0, 0, -DEPTH_ONE, 1, 2, 3, 4);                // equal depth passes
    queue_frag(0, 0, -DEPTH_ONE - 1, 5, 5, 5, 5);
    queue_frag(255, 255, DEPTH_ONE + 1, 5, 5, 5, 5);
    queue_frag(0, 0, 32767, 255, 0, 255, 0);
    queue_frag(0, 0, -32768, 0, 255, 0, 255);
    queue_frag(-1, 0, 0, 7, 7, 7, 7);
    queue_frag(256, 0, 0, 7, 7, 7, 7);
    queue_frag(0, -1, 0, 7, 7, 7, 7);
    queue_frag(0, 256, 0, 7, 7, 7, 7);
    queue_frag(-2048, -2048, 0, 7, 7, 7, 7);
    queue_frag(2047, 2047, 0, 7, 7, 7, 7);
    queue_frag(-1, 5, 30000, 7, 7, 7, 7);                    // clipped and behind
    queue_frag(128, 128, 0, 255, 0, 255, 255);
    queue_frag(128, 128, 0, 0, 255, 0, 0);                   // keep dst, alpha 0
    queue_frag(128, 128, 1, 1, 1, 1, 1);                     // just behind
    queue_frag(128, 128, -1, 254, 1, 128, 127);

    for (int p = 0; p < 9; p++) begin
      wait_idle();
      if (p == 8) no_idle = 1'b1;
      case (p)
        0: apply_settings(255, 255, 511, 511, 1'b0, 1'b1);
        1: apply_settings(0, 0, 0, 0, 1'b1, 1'b0);
        2: apply_settings(0, 0, 256, 256, 1'b1, 1'b1);
        3: apply_settings(0, 0, 511, 511, 1'b0, 1'b0);
        default: begin
          vx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48);
          vy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48);
          vw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
          vh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
          apply_settings(vx, vy, vw, vh, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
      if (p == 2) hold_requests++;
      n = (p < 2) ? 25 : 80;
      for (int i = 0; i < n; i++) push_frag(random_fragment());
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d fragments under %0d register settings, with readback each time.",
             frags_taken, settings_used);
    $display("Predicted %0d written, %0d clipped, %0d behind stored depth; %0d mismatches.",
             n_written, n_clipped, n_zfail, mismatches + reg_errors);
    if (mismatches == 0 && reg_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fcdbw_pkg.sv
rtl/fcdbw_ifs.sv
rtl/fcdbw_regs.sv
rtl/fcdbw_front.sv
rtl/fcdbw_queue.sv
rtl/fcdbw_back.sv
rtl/fragment_clip_depth_blend_write.sv
tb/tb_fragment_clip_depth_blend_write.sv
